### design/mvbt_pkg.sv
// shared types and constants of the motion vector box tracker
`timescale 1ns / 1ps

package mvbt_pkg;

    // fixed field widths
    localparam int BLK_W   = 10;
    localparam int VEC_W   = 16;
    localparam int FRAME_W = 32;
    localparam int DIM_W   = 12;
    localparam int POS_W   = 24;
    localparam int SUM_W   = 36;
    localparam int CNT_W   = 20;
    localparam int ID_W    = 32;
    localparam int GAP_W   = 16;
    localparam int SRC_W   = 2;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [POS_W-1:0] POS_MAX   = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};

    // configuration register index
    typedef enum logic [0:0] {
        REG_SEARCH_GAP  = 1'b0,
        REG_CONFIRM_GAP = 1'b1
    } cfg_reg_t;

    // where an output box came from
    typedef enum logic [SRC_W-1:0] {
        SRC_NEW     = 2'd0,
        SRC_REFRESH = 2'd1,
        SRC_MOTION  = 2'd2
    } box_src_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_UPDATE
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic     motion;
        logic     set_last;
        logic     drop;
        logic     load_box;
        logic     new_track;
        logic     div_start;
        logic     div_step;
        logic     move;
        logic     emit;
        box_src_t src;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic tracking;
        logic confirm_due;
        logic search_due;
        logic out_busy;
    } dp_status_t;

endpackage

### design/mvbt_ctrl.sv
// controller state machine of the motion vector box tracker
`timescale 1ns / 1ps

module mvbt_ctrl
    import mvbt_pkg::*;
#(
    parameter int STEPS = 42
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic       det_found,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam int SC_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    ctrl_state_t      state_reg, state_next;
    logic [SC_W-1:0]  step_cnt_reg, step_cnt_next;
    logic             step_last;
    logic             accept;
    logic             frame_acc;

    assign step_last = (step_cnt_reg == SC_W'(STEPS - 1));
    assign in_stall  = (state_reg != ST_IDLE) || (req_type && status.out_busy);
    assign accept    = in_valid && !in_stall;
    assign frame_acc = accept && req_type;

    // state and step counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_cnt_next = '0;
                if (frame_acc && status.tracking && !status.confirm_due)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                step_cnt_next = step_cnt_reg + SC_W'(1);
                if (step_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd        = '0;
        cmd.src    = SRC_NEW;
        cmd.motion = accept && !req_type;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame_acc)
                begin
                    if (status.tracking)
                    begin
                        if (status.confirm_due)
                        begin
                            cmd.set_last = 1'b1;
                            cmd.drop     = !det_found;
                            cmd.load_box = det_found;
                            cmd.emit     = det_found;
                            cmd.src      = SRC_REFRESH;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                        end
                    end
                    else if (status.search_due)
                    begin
                        cmd.set_last  = 1'b1;
                        cmd.load_box  = det_found;
                        cmd.new_track = det_found;
                        cmd.emit      = det_found;
                        cmd.src       = SRC_NEW;
                    end
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.move = 1'b1;
                cmd.emit = 1'b1;
                cmd.src  = SRC_MOTION;
            end
            default:
            begin
                cmd.motion = 1'b0;
            end
        endcase
    end

    // no motion sample is taken while a frame transaction is in the divider
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !cmd.motion)
        else $error("motion sample accepted while busy");

    // the divider hands over to the box update after its last step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE && step_last) |=> (state_reg == ST_UPDATE))
        else $error("divider did not hand over to update");

endmodule

### design/mvbt_datapath.sv
// datapath of the motion vector box tracker: box state, sums, divider, output register
`timescale 1ns / 1ps

module mvbt_datapath
    import mvbt_pkg::*;
#(
    parameter int FRAC_BITS    = 8,
    parameter int BLOCK_PIXELS = 4,
    parameter int STEPS        = 42
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctrl_cmd_t                  cmd,
    output dp_status_t                 status,
    input  logic [GAP_W-1:0]           search_gap,
    input  logic [GAP_W-1:0]           confirm_gap,
    input  logic [BLK_W-1:0]           block_col,
    input  logic [BLK_W-1:0]           block_row,
    input  logic signed [VEC_W-1:0]    vec_x,
    input  logic signed [VEC_W-1:0]    vec_y,
    input  logic [FRAME_W-1:0]         frame_index,
    input  logic [DIM_W-1:0]           det_left,
    input  logic [DIM_W-1:0]           det_top,
    input  logic [DIM_W-1:0]           det_width,
    input  logic [DIM_W-1:0]           det_height,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [ID_W-1:0]            track_id,
    output logic [FRAME_W-1:0]         out_frame,
    output logic signed [POS_W-1:0]    box_left,
    output logic signed [POS_W-1:0]    box_top,
    output logic [DIM_W-1:0]           box_width,
    output logic [DIM_W-1:0]           box_height,
    output logic [SRC_W-1:0]           box_source
);

    // pixel coordinate of a block corner and the signed compare width
    localparam int PIX_W = $clog2((1 << BLK_W) * BLOCK_PIXELS + 1);
    localparam int CW    = ((PIX_W + FRAC_BITS > POS_W) ? PIX_W + FRAC_BITS : POS_W) + 2;
    // dividend is |sum| * 2^FRAC / 4, quotient magnitude fits QW bits
    localparam int NW    = STEPS;
    localparam int QW    = 14 + FRAC_BITS;
    localparam int RW    = ((QW > POS_W) ? QW : POS_W) + 2;

    localparam logic signed [RW-1:0] R_MAX = RW'($signed(POS_MAX));
    localparam logic signed [RW-1:0] R_MIN = RW'($signed(POS_MIN));

    // tracker state
    logic                       tracking_reg, tracking_next;
    logic signed [POS_W-1:0]    cur_left_reg, cur_left_next;
    logic signed [POS_W-1:0]    cur_top_reg, cur_top_next;
    logic [DIM_W-1:0]           cur_width_reg, cur_width_next;
    logic [DIM_W-1:0]           cur_height_reg, cur_height_next;
    logic signed [SUM_W-1:0]    sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0]    sum_y_reg, sum_y_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [FRAME_W-1:0]         last_search_reg, last_search_next;
    logic [ID_W-1:0]            cur_id_reg, cur_id_next;
    logic [ID_W-1:0]            next_id_reg, next_id_next;
    logic [FRAME_W-1:0]         pend_frame_reg, pend_frame_next;

    // divider lanes
    logic [NW-1:0]              num_x_reg, num_x_next;
    logic [NW-1:0]              num_y_reg, num_y_next;
    logic [CNT_W-1:0]           rem_x_reg, rem_x_next;
    logic [CNT_W-1:0]           rem_y_reg, rem_y_next;
    logic                       neg_x_reg, neg_x_next;
    logic                       neg_y_reg, neg_y_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [ID_W-1:0]            track_id_reg, track_id_next;
    logic [FRAME_W-1:0]         out_frame_reg, out_frame_next;
    logic signed [POS_W-1:0]    box_left_reg, box_left_next;
    logic signed [POS_W-1:0]    box_top_reg, box_top_next;
    logic [DIM_W-1:0]           box_width_reg, box_width_next;
    logic [DIM_W-1:0]           box_height_reg, box_height_next;
    logic [SRC_W-1:0]           box_source_reg, box_source_next;

    logic [FRAME_W-1:0]         diff;
    logic [PIX_W-1:0]           px0, px1, py0, py1;
    logic signed [CW-1:0]       sx0, sx1, sy0, sy1;
    logic signed [CW-1:0]       lim_l, lim_r, lim_t, lim_b;
    logic                       x_in, y_in, hit, add_ok;
    logic signed [POS_W-1:0]    ld_left, ld_top, mv_left, mv_top;
    logic [SUM_W-1:0]           mag_x, mag_y;
    logic [CNT_W:0]             trial_x, trial_y;
    logic [CNT_W:0]             diff_x, diff_y;

    // saturated edge from a detected pixel edge
    function automatic logic signed [POS_W-1:0] sat_edge(input logic [DIM_W-1:0] e);
        logic [31:0] w;
        w = 32'(e) << FRAC_BITS;
        return (w > 32'(POS_MAX)) ? POS_MAX : w[POS_W-1:0];
    endfunction

    // box moved against the mean vector, saturated
    function automatic logic signed [POS_W-1:0] move_edge(
        input logic signed [POS_W-1:0] cur,
        input logic [NW-1:0]           q,
        input logic                    neg
    );
        logic signed [RW-1:0] shift;
        logic signed [RW-1:0] v;
        shift = $signed(RW'(q[QW-1:0]));
        if (neg)
        begin
            shift = -shift;
        end
        v = RW'(cur) - shift;
        if (v > R_MAX)
        begin
            return POS_MAX;
        end
        else if (v < R_MIN)
        begin
            return POS_MIN;
        end
        return v[POS_W-1:0];
    endfunction

    // frame distance and hysteresis status
    assign diff                = frame_index - last_search_reg;
    assign status.tracking     = tracking_reg;
    assign status.confirm_due  = (diff >= FRAME_W'(confirm_gap)) || (count_reg == '0);
    assign status.search_due   = (diff >= FRAME_W'(search_gap));
    assign status.out_busy     = out_valid_reg;

    // block corner test against the box, bounds inclusive
    assign px0   = PIX_W'(block_col) * PIX_W'(BLOCK_PIXELS);
    assign py0   = PIX_W'(block_row) * PIX_W'(BLOCK_PIXELS);
    assign px1   = px0 + PIX_W'(BLOCK_PIXELS);
    assign py1   = py0 + PIX_W'(BLOCK_PIXELS);
    assign sx0   = $signed(CW'({px0, {FRAC_BITS{1'b0}}}));
    assign sx1   = $signed(CW'({px1, {FRAC_BITS{1'b0}}}));
    assign sy0   = $signed(CW'({py0, {FRAC_BITS{1'b0}}}));
    assign sy1   = $signed(CW'({py1, {FRAC_BITS{1'b0}}}));
    assign lim_l = CW'(cur_left_reg);
    assign lim_t = CW'(cur_top_reg);
    assign lim_r = lim_l + $signed(CW'({cur_width_reg, {FRAC_BITS{1'b0}}}));
    assign lim_b = lim_t + $signed(CW'({cur_height_reg, {FRAC_BITS{1'b0}}}));
    assign x_in  = (sx0 >= lim_l && sx0 <= lim_r) || (sx1 >= lim_l && sx1 <= lim_r);
    assign y_in  = (sy0 >= lim_t && sy0 <= lim_b) || (sy1 >= lim_t && sy1 <= lim_b);
    assign hit   = x_in && y_in;
    assign add_ok = cmd.motion && tracking_reg && (count_reg != COUNT_MAX) && hit;

    // new box candidates
    assign ld_left = sat_edge(det_left);
    assign ld_top  = sat_edge(det_top);
    assign mv_left = move_edge(cur_left_reg, num_x_reg, neg_x_reg);
    assign mv_top  = move_edge(cur_top_reg, num_y_reg, neg_y_reg);

    // divider operand magnitudes and one restoring step per lane
    assign mag_x   = sum_x_reg[SUM_W-1] ? SUM_W'(-sum_x_reg) : SUM_W'(sum_x_reg);
    assign mag_y   = sum_y_reg[SUM_W-1] ? SUM_W'(-sum_y_reg) : SUM_W'(sum_y_reg);
    assign trial_x = {rem_x_reg, num_x_reg[NW-1]};
    assign trial_y = {rem_y_reg, num_y_reg[NW-1]};
    assign diff_x  = trial_x - {1'b0, count_reg};
    assign diff_y  = trial_y - {1'b0, count_reg};

    // next state of tracker, divider and output
    always_comb
    begin
        tracking_next    = tracking_reg;
        cur_left_next    = cur_left_reg;
        cur_top_next     = cur_top_reg;
        cur_width_next   = cur_width_reg;
        cur_height_next  = cur_height_reg;
        sum_x_next       = sum_x_reg;
        sum_y_next       = sum_y_reg;
        count_next       = count_reg;
        last_search_next = last_search_reg;
        cur_id_next      = cur_id_reg;
        next_id_next     = next_id_reg;
        pend_frame_next  = pend_frame_reg;
        num_x_next       = num_x_reg;
        num_y_next       = num_y_reg;
        rem_x_next       = rem_x_reg;
        rem_y_next       = rem_y_reg;
        neg_x_next       = neg_x_reg;
        neg_y_next       = neg_y_reg;
        out_valid_next   = out_valid_reg && out_stall;
        track_id_next    = track_id_reg;
        out_frame_next   = out_frame_reg;
        box_left_next    = box_left_reg;
        box_top_next     = box_top_reg;
        box_width_next   = box_width_reg;
        box_height_next  = box_height_reg;
        box_source_next  = box_source_reg;

        // motion sample accumulation
        if (add_ok)
        begin
            sum_x_next = sum_x_reg + SUM_W'(vec_x);
            sum_y_next = sum_y_reg + SUM_W'(vec_y);
            count_next = count_reg + CNT_W'(1);
        end

        if (cmd.set_last)
        begin
            last_search_next = frame_index;
        end
        if (cmd.drop)
        begin
            tracking_next = 1'b0;
        end
        if (cmd.new_track)
        begin
            tracking_next = 1'b1;
            cur_id_next   = next_id_reg;
            next_id_next  = next_id_reg + ID_W'(1);
        end

        // box reload from the detector
        if (cmd.load_box)
        begin
            cur_left_next   = ld_left;
            cur_top_next    = ld_top;
            cur_width_next  = det_width;
            cur_height_next = det_height;
            sum_x_next      = '0;
            sum_y_next      = '0;
            count_next      = '0;
        end

        // divider start and steps
        if (cmd.div_start)
        begin
            pend_frame_next = frame_index;
            neg_x_next      = sum_x_reg[SUM_W-1];
            neg_y_next      = sum_y_reg[SUM_W-1];
            num_x_next      = NW'({mag_x, {(FRAC_BITS-2){1'b0}}});
            num_y_next      = NW'({mag_y, {(FRAC_BITS-2){1'b0}}});
            rem_x_next      = '0;
            rem_y_next      = '0;
        end
        if (cmd.div_step)
        begin
            if (!diff_x[CNT_W])
            begin
                rem_x_next = diff_x[CNT_W-1:0];
                num_x_next = {num_x_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_x_next = trial_x[CNT_W-1:0];
                num_x_next = {num_x_reg[NW-2:0], 1'b0};
            end
            if (!diff_y[CNT_W])
            begin
                rem_y_next = diff_y[CNT_W-1:0];
                num_y_next = {num_y_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_y_next = trial_y[CNT_W-1:0];
                num_y_next = {num_y_reg[NW-2:0], 1'b0};
            end
        end

        // box move by the mean vector
        if (cmd.move)
        begin
            cur_left_next = mv_left;
            cur_top_next  = mv_top;
            sum_x_next    = '0;
            sum_y_next    = '0;
            count_next    = '0;
        end

        // output transaction
        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            track_id_next   = cmd.new_track ? next_id_reg : cur_id_reg;
            out_frame_next  = cmd.move ? pend_frame_reg : frame_index;
            box_left_next   = cur_left_next;
            box_top_next    = cur_top_next;
            box_width_next  = cur_width_next;
            box_height_next = cur_height_next;
            box_source_next = cmd.src;
        end
    end

    // registers cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_reg    <= 1'b0;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            count_reg       <= '0;
            last_search_reg <= '0;
            next_id_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            tracking_reg    <= tracking_next;
            sum_x_reg       <= sum_x_next;
            sum_y_reg       <= sum_y_next;
            count_reg       <= count_next;
            last_search_reg <= last_search_next;
            next_id_reg     <= next_id_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_left_reg    <= cur_left_next;
        cur_top_reg     <= cur_top_next;
        cur_width_reg   <= cur_width_next;
        cur_height_reg  <= cur_height_next;
        cur_id_reg      <= cur_id_next;
        pend_frame_reg  <= pend_frame_next;
        num_x_reg       <= num_x_next;
        num_y_reg       <= num_y_next;
        rem_x_reg       <= rem_x_next;
        rem_y_reg       <= rem_y_next;
        neg_x_reg       <= neg_x_next;
        neg_y_reg       <= neg_y_next;
        track_id_reg    <= track_id_next;
        out_frame_reg   <= out_frame_next;
        box_left_reg    <= box_left_next;
        box_top_reg     <= box_top_next;
        box_width_reg   <= box_width_next;
        box_height_reg  <= box_height_next;
        box_source_reg  <= box_source_next;
    end

    assign out_valid  = out_valid_reg;
    assign track_id   = track_id_reg;
    assign out_frame  = out_frame_reg;
    assign box_left   = box_left_reg;
    assign box_top    = box_top_reg;
    assign box_width  = box_width_reg;
    assign box_height = box_height_reg;
    assign box_source = box_source_reg;

    // a new result never overwrites one that still waits
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_valid_reg)
        else $error("result register overwritten");

    // the divider only starts with samples on hand
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (tracking_reg && count_reg != '0))
        else $error("divide started without samples");

endmodule

### design/motion_vector_box_tracker_core.sv
// top level of the motion vector box tracker
`timescale 1ns / 1ps

// Motion vector box tracker. Input transactions (in_valid / in_stall) carry
// either a motion sample (req_type 0) or a frame boundary with a detector
// result (req_type 1). Result transactions (out_valid / out_stall) carry one
// box per frame boundary that yields one; motion samples never give a result.
// Motion samples are taken one per cycle, also while a result waits, except
// while a box move runs. A frame boundary that starts, refreshes or drops a
// track is taken and any result it yields is valid the next cycle. A frame
// boundary that moves the box by the mean vector runs a restoring divider, one
// quotient bit per cycle on both axes at once, FRAC_BITS + 34 steps; in_stall
// stays high through the divide steps and the update state, and the result is
// registered in the update state.
// A frame boundary is held off while a result still waits at the output.
// The output register holds its transaction stable while out_stall is high.
// Reset clears the track, the sums, the next track id and both gap registers.
// Gap registers sit on the APB port: search_gap at 0x0, confirm_gap at 0x4.

module motion_vector_box_tracker_core
    import mvbt_pkg::*;
#(
    parameter int FRAC_BITS    = 8,
    parameter int BLOCK_PIXELS = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     req_type,
    input  logic [BLK_W-1:0]         block_col,
    input  logic [BLK_W-1:0]         block_row,
    input  logic signed [VEC_W-1:0]  vec_x,
    input  logic signed [VEC_W-1:0]  vec_y,
    input  logic [FRAME_W-1:0]       frame_index,
    input  logic                     det_found,
    input  logic [DIM_W-1:0]         det_left,
    input  logic [DIM_W-1:0]         det_top,
    input  logic [DIM_W-1:0]         det_width,
    input  logic [DIM_W-1:0]         det_height,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [ID_W-1:0]          track_id,
    output logic [FRAME_W-1:0]       out_frame,
    output logic signed [POS_W-1:0]  box_left,
    output logic signed [POS_W-1:0]  box_top,
    output logic [DIM_W-1:0]         box_width,
    output logic [DIM_W-1:0]         box_height,
    output logic [SRC_W-1:0]         box_source
);

    localparam int STEPS = SUM_W + FRAC_BITS - 2;

    logic [GAP_W-1:0] search_gap_reg, search_gap_next;
    logic [GAP_W-1:0] confirm_gap_reg, confirm_gap_next;
    logic             cfg_write;
    cfg_reg_t         cfg_sel;
    ctrl_cmd_t        cmd;
    dp_status_t       status;

    // apb register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = cfg_reg_t'(paddr[2]);

    always_comb
    begin
        search_gap_next  = search_gap_reg;
        confirm_gap_next = confirm_gap_reg;
        prdata           = '0;
        unique case (cfg_sel)
            REG_SEARCH_GAP:
            begin
                prdata = APB_DW'(search_gap_reg);
                if (cfg_write)
                begin
                    search_gap_next = pwdata[GAP_W-1:0];
                end
            end
            REG_CONFIRM_GAP:
            begin
                prdata = APB_DW'(confirm_gap_reg);
                if (cfg_write)
                begin
                    confirm_gap_next = pwdata[GAP_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_gap_reg  <= '0;
            confirm_gap_reg <= '0;
        end
        else
        begin
            search_gap_reg  <= search_gap_next;
            confirm_gap_reg <= confirm_gap_next;
        end
    end

    // controller
    mvbt_ctrl #(
        .STEPS (STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .det_found (det_found),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    mvbt_datapath #(
        .FRAC_BITS    (FRAC_BITS),
        .BLOCK_PIXELS (BLOCK_PIXELS),
        .STEPS        (STEPS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .search_gap  (search_gap_reg),
        .confirm_gap (confirm_gap_reg),
        .block_col   (block_col),
        .block_row   (block_row),
        .vec_x       (vec_x),
        .vec_y       (vec_y),
        .frame_index (frame_index),
        .det_left    (det_left),
        .det_top     (det_top),
        .det_width   (det_width),
        .det_height  (det_height),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .track_id    (track_id),
        .out_frame   (out_frame),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_width   (box_width),
        .box_height  (box_height),
        .box_source  (box_source)
    );

endmodule

### dv/tb_top.sv
// self-checking testbench for the motion vector box tracker core
`timescale 1ns / 1ps

module tb_top;
    import mvbt_pkg::*;

    localparam int     FRAC       = 8;
    localparam int     BLK_PX     = 4;
    localparam int     QPEL       = 4;
    localparam longint SCALE      = longint'(1) << FRAC;
    localparam longint LIMIT      = 1000000;
    localparam int     DRAIN_MAX  = 20000;
    localparam int     DRAIN_TAIL = FRAC + 52;
    localparam int     PHASE_LEN  = 300;
    localparam int     HOLD_LEN   = 400;

    // request kinds on req_type
    localparam logic REQ_MOTION = 1'b0;
    localparam logic REQ_FRAME  = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [BLK_W-1:0]        block_col;
        logic [BLK_W-1:0]        block_row;
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
        logic [FRAME_W-1:0]      frame_index;
        logic                    det_found;
        logic [DIM_W-1:0]        det_left;
        logic [DIM_W-1:0]        det_top;
        logic [DIM_W-1:0]        det_width;
        logic [DIM_W-1:0]        det_height;
    } tracker_req_t;

    typedef struct packed {
        logic [ID_W-1:0]         track_id;
        logic [FRAME_W-1:0]      out_frame;
        logic signed [POS_W-1:0] box_left;
        logic signed [POS_W-1:0] box_top;
        logic [DIM_W-1:0]        box_width;
        logic [DIM_W-1:0]        box_height;
        box_src_t                box_source;
    } tracker_box_t;

    typedef struct packed {
        logic         is_cfg;
        cfg_reg_t     reg_idx;
        logic [GAP_W-1:0] reg_val;
        tracker_req_t req;
        logic         typed;
        tracker_box_t want;
    } script_row_t;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    psel        = 1'b0;
    logic                    penable     = 1'b0;
    logic                    pwrite      = 1'b0;
    logic [APB_AW-1:0]       paddr       = '0;
    logic [APB_DW-1:0]       pwdata      = '0;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;
    logic                    in_valid    = 1'b0;
    logic                    in_stall;
    logic                    req_type    = 1'b0;
    logic [BLK_W-1:0]        block_col   = '0;
    logic [BLK_W-1:0]        block_row   = '0;
    logic signed [VEC_W-1:0] vec_x       = '0;
    logic signed [VEC_W-1:0] vec_y       = '0;
    logic [FRAME_W-1:0]      frame_index = '0;
    logic                    det_found   = 1'b0;
    logic [DIM_W-1:0]        det_left    = '0;
    logic [DIM_W-1:0]        det_top     = '0;
    logic [DIM_W-1:0]        det_width   = '0;
    logic [DIM_W-1:0]        det_height  = '0;
    logic                    out_valid;
    logic                    out_stall   = 1'b0;
    logic [ID_W-1:0]         track_id;
    logic [FRAME_W-1:0]      out_frame;
    logic signed [POS_W-1:0] box_left;
    logic signed [POS_W-1:0] box_top;
    logic [DIM_W-1:0]        box_width;
    logic [DIM_W-1:0]        box_height;
    logic [SRC_W-1:0]        box_source;

    // tracker state mirrored by the predictor
    logic               trk_on      = 1'b0;
    longint             trk_left    = 0;
    longint             trk_top     = 0;
    logic [DIM_W-1:0]   trk_w       = '0;
    logic [DIM_W-1:0]   trk_h       = '0;
    longint             acc_x       = 0;
    longint             acc_y       = 0;
    logic [CNT_W-1:0]   n_samples   = '0;
    logic [FRAME_W-1:0] last_search = '0;
    logic [ID_W-1:0]    id_cur      = '0;
    logic [ID_W-1:0]    id_next     = '0;
    logic [GAP_W-1:0]   gap_search  = '0;
    logic [GAP_W-1:0]   gap_confirm = '0;

    tracker_box_t       pending_boxes[$];
    script_row_t        script[$];
    logic [FRAME_W-1:0] frame_cur     = '0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 hold_len      = 0;
    int                 n_errors      = 0;
    int                 n_effective   = 0;
    int                 n_sat_hits    = 0;
    int                 n_src[4]      = '{0, 0, 0, 0};
    longint             cycle_cnt     = 0;

    motion_vector_box_tracker_core #(
        .FRAC_BITS    (FRAC),
        .BLOCK_PIXELS (BLK_PX)
    ) dut (.*);

    always #10 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT)
        begin
            $display("timeout after %0d cycles, %0d boxes outstanding",
                     LIMIT, pending_boxes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (n_errors < 40)
            $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    function automatic longint clamp_pos(input longint v);
        if (v > longint'(POS_MAX))
            return longint'(POS_MAX);
        if (v < -longint'(POS_MIN))
            return -longint'(POS_MIN);
        return v;
    endfunction

    // inclusive point-in-box test in Q.FRAC
    function automatic bit corner_hit(input longint px, input longint py);
        longint sx;
        longint sy;
        sx = px * SCALE;
        sy = py * SCALE;
        return sx >= trk_left && sx <= trk_left + longint'(trk_w) * SCALE &&
               sy >= trk_top && sy <= trk_top + longint'(trk_h) * SCALE;
    endfunction

    function automatic tracker_box_t box_now(input logic [FRAME_W-1:0] f, input box_src_t src);
        tracker_box_t b;
        b.track_id   = id_cur;
        b.out_frame  = f;
        b.box_left   = trk_left[POS_W-1:0];
        b.box_top    = trk_top[POS_W-1:0];
        b.box_width  = trk_w;
        b.box_height = trk_h;
        b.box_source = src;
        return b;
    endfunction

    task automatic load_det(input tracker_req_t r);
        trk_left  = clamp_pos(longint'(r.det_left) * SCALE);
        trk_top   = clamp_pos(longint'(r.det_top) * SCALE);
        trk_w     = r.det_width;
        trk_h     = r.det_height;
        acc_x     = 0;
        acc_y     = 0;
        n_samples = '0;
    endtask

    // next tracker state and the box a transaction yields
    task automatic track_step(input tracker_req_t r, output bit has_box,
                              output tracker_box_t b, output bit took);
        logic [FRAME_W-1:0] diff;
        longint             px;
        longint             py;
        longint             den;
        has_box = 1'b0;
        took    = 1'b0;
        b       = '0;
        diff    = r.frame_index - last_search;
        if (r.req_type == REQ_MOTION)
        begin
            if (trk_on && n_samples == COUNT_MAX)
                n_sat_hits++;
            if (trk_on && n_samples != COUNT_MAX)
            begin
                px = longint'(r.block_col) * BLK_PX;
                py = longint'(r.block_row) * BLK_PX;
                if (corner_hit(px, py) || corner_hit(px + BLK_PX, py) ||
                    corner_hit(px, py + BLK_PX) || corner_hit(px + BLK_PX, py + BLK_PX))
                begin
                    acc_x     += longint'(r.vec_x);
                    acc_y     += longint'(r.vec_y);
                    n_samples += CNT_W'(1);
                    took       = 1'b1;
                end
            end
        end
        else if (trk_on)
        begin
            took = 1'b1;
            if (diff >= FRAME_W'(gap_confirm) || n_samples == '0)
            begin
                last_search = r.frame_index;
                if (!r.det_found)
                    trk_on = 1'b0;
                else
                begin
                    load_det(r);
                    has_box = 1'b1;
                    b       = box_now(r.frame_index, SRC_REFRESH);
                end
            end
            else
            begin
                // move by minus the mean vector, truncated toward zero
                den       = longint'(QPEL) * longint'(n_samples);
                trk_left  = clamp_pos(trk_left - (acc_x * SCALE) / den);
                trk_top   = clamp_pos(trk_top - (acc_y * SCALE) / den);
                acc_x     = 0;
                acc_y     = 0;
                n_samples = '0;
                has_box   = 1'b1;
                b         = box_now(r.frame_index, SRC_MOTION);
            end
        end
        else if (diff >= FRAME_W'(gap_search))
        begin
            took        = 1'b1;
            last_search = r.frame_index;
            if (r.det_found)
            begin
                id_cur  = id_next;
                id_next = id_next + ID_W'(1);
                load_det(r);
                trk_on  = 1'b1;
                has_box = 1'b1;
                b       = box_now(r.frame_index, SRC_NEW);
            end
        end
    endtask

    // offer one transaction, wait for acceptance, then predict
    task automatic send_req(input tracker_req_t r, input logic typed,
                            input tracker_box_t want);
        bit           has_box;
        bit           took;
        tracker_box_t b;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat (($urandom_range(9) == 0) ? $urandom_range(7, 60) : $urandom_range(1, 6))
                @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= r.req_type;
        block_col   <= r.block_col;
        block_row   <= r.block_row;
        vec_x       <= r.vec_x;
        vec_y       <= r.vec_y;
        frame_index <= r.frame_index;
        det_found   <= r.det_found;
        det_left    <= r.det_left;
        det_top     <= r.det_top;
        det_width   <= r.det_width;
        det_height  <= r.det_height;
        do
            @(posedge clk);
        while (in_stall);
        track_step(r, has_box, b, took);
        if (has_box)
            pending_boxes.push_back(typed ? want : b);
        if (took)
            n_effective++;
    endtask

    // wait for all boxes, then for the divider to be surely done
    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pending_boxes.size() != 0 && waited < DRAIN_MAX)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // apb write followed by a readback
    task automatic write_reg(input cfg_reg_t idx, input logic [GAP_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == REG_SEARCH_GAP)
            gap_search = val;
        else
            gap_confirm = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[GAP_W-1:0] !== val)
            report_mismatch("register readback", prdata, val);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic add_cfg(input cfg_reg_t idx, input logic [GAP_W-1:0] val);
        script_row_t row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        script.push_back(row);
    endtask

    task automatic add_motion(input logic [BLK_W-1:0] col, input logic [BLK_W-1:0] rw,
                              input logic signed [VEC_W-1:0] vx,
                              input logic signed [VEC_W-1:0] vy);
        script_row_t row;
        row               = '0;
        row.req.req_type  = REQ_MOTION;
        row.req.block_col = col;
        row.req.block_row = rw;
        row.req.vec_x     = vx;
        row.req.vec_y     = vy;
        script.push_back(row);
    endtask

    task automatic add_frame(input logic [FRAME_W-1:0] f, input logic found,
                             input logic [DIM_W-1:0] l, input logic [DIM_W-1:0] t,
                             input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        script_row_t row;
        row                 = '0;
        row.req.req_type    = REQ_FRAME;
        row.req.frame_index = f;
        row.req.det_found   = found;
        row.req.det_left    = l;
        row.req.det_top     = t;
        row.req.det_width   = w;
        row.req.det_height  = h;
        script.push_back(row);
    endtask

    // expected box of the row added last
    task automatic add_typed(input logic [ID_W-1:0] id, input logic [FRAME_W-1:0] f,
                             input longint l, input longint t,
                             input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input box_src_t src);
        script_row_t row;
        row                 = script.pop_back();
        row.typed           = 1'b1;
        row.want.track_id   = id;
        row.want.out_frame  = f;
        row.want.box_left   = l[POS_W-1:0];
        row.want.box_top    = t[POS_W-1:0];
        row.want.box_width  = w;
        row.want.box_height = h;
        row.want.box_source = src;
        script.push_back(row);
    endtask

    function automatic logic signed [VEC_W-1:0] pick_vec();
        logic [VEC_W-1:0] v;
        if ($urandom_range(9) < 6)
            v = VEC_W'($urandom_range(0, 256)) - VEC_W'(128);
        else
            v = VEC_W'($urandom);
        return $signed(v);
    endfunction

    function automatic logic [BLK_W-1:0] pick_block(input longint edge_q, input int span);
        int p;
        p = int'(edge_q / SCALE) + int'($urandom_range(0, span + 8)) - 6;
        if (p < 0)
            p = 0;
        p = p / BLK_PX;
        return (p > 1023) ? BLK_W'(1023) : BLK_W'(p);
    endfunction

    // random transaction: mostly boxes followed by samples on them
    task automatic rand_req(output tracker_req_t r);
        int pick;
        r = '0;
        if ($urandom_range(7) == 0 || (!trk_on && $urandom_range(1) == 0))
        begin
            pick = $urandom_range(19);
            if (pick == 0)
                frame_cur = FRAME_W'($urandom);
            else if (pick == 1)
                frame_cur = frame_cur - FRAME_W'($urandom_range(1, 200));
            else if (pick < 6)
                frame_cur = frame_cur + FRAME_W'($urandom_range(1, 140000));
            else
                frame_cur = frame_cur + FRAME_W'($urandom_range(1, 3));
            r.req_type    = REQ_FRAME;
            r.frame_index = frame_cur;
            r.det_found   = ($urandom_range(99) < 85);
            r.det_left    = DIM_W'($urandom);
            r.det_top     = DIM_W'($urandom);
            r.det_width   = ($urandom_range(9) < 7) ? DIM_W'($urandom_range(0, 200))
                                                    : DIM_W'($urandom);
            r.det_height  = ($urandom_range(9) < 7) ? DIM_W'($urandom_range(0, 200))
                                                    : DIM_W'($urandom);
        end
        else
        begin
            r.req_type = REQ_MOTION;
            if (trk_on && $urandom_range(9) < 8)
            begin
                r.block_col = pick_block(trk_left, int'(trk_w));
                r.block_row = pick_block(trk_top, int'(trk_h));
            end
            else
            begin
                r.block_col = BLK_W'($urandom);
                r.block_row = BLK_W'($urandom);
            end
            r.vec_x       = pick_vec();
            r.vec_y       = pick_vec();
            r.frame_index = FRAME_W'($urandom);
            r.det_found   = 1'($urandom_range(1));
            r.det_left    = DIM_W'($urandom);
            r.det_top     = DIM_W'($urandom);
            r.det_width   = DIM_W'($urandom);
            r.det_height  = DIM_W'($urandom);
        end
    endtask

    // receiver stalls, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_len > 0)
        begin
            out_stall <= 1'b1;
            hold_len  <= hold_len - 1;
        end
        else
            out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end

    // compare each delivered box with the oldest expectation
    always @(posedge clk)
    begin
        tracker_box_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_src[box_source]++;
            if (pending_boxes.size() == 0)
                report_mismatch("box with nothing expected, frame", out_frame, 0);
            else
            begin
                want = pending_boxes.pop_front();
                if (track_id !== want.track_id)
                    report_mismatch("track_id", track_id, want.track_id);
                if (out_frame !== want.out_frame)
                    report_mismatch("out_frame", out_frame, want.out_frame);
                if (box_left !== want.box_left)
                    report_mismatch("box_left", box_left, want.box_left);
                if (box_top !== want.box_top)
                    report_mismatch("box_top", box_top, want.box_top);
                if (box_width !== want.box_width)
                    report_mismatch("box_width", box_width, want.box_width);
                if (box_height !== want.box_height)
                    report_mismatch("box_height", box_height, want.box_height);
                if (box_source !== want.box_source)
                    report_mismatch("box_source", box_source, want.box_source);
            end
        end
    end

    // stimulus
    initial
    begin
        tracker_req_t r;
        tracker_box_t no_box;
        int           done;
        logic [GAP_W-1:0] s_gap[6];
        logic [GAP_W-1:0] c_gap[6];

        no_box = '0;
        s_gap  = '{16'd0, 16'd3, 16'hFFFF, 16'd0, 16'd0, 16'd5};
        c_gap  = '{16'd0, 16'd8, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1};
        s_gap[3] = GAP_W'($urandom_range(1, 40));
        c_gap[3] = GAP_W'($urandom_range(1, 40));

        // directed script, run at the reset gap values first
        add_frame(32'd0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0);
        add_motion(10'd5, 10'd5, 16'sd100, -16'sd100);
        add_frame(32'd1, 1'b1, 12'd10, 12'd20, 12'd30, 12'd40);
        add_typed(32'd0, 32'd1, 2560, 5120, 12'd30, 12'd40, SRC_NEW);
        add_frame(32'd2, 1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        add_typed(32'd0, 32'd2, 1048320, 1048320, 12'd4095, 12'd4095, SRC_REFRESH);
        add_motion(10'd0, 10'd0, -16'sd32768, 16'sd32767);
        add_frame(32'd3, 1'b0, 12'd5, 12'd5, 12'd5, 12'd5);
        add_frame(32'd4, 1'b1, 12'd0, 12'd0, 12'd0, 12'd0);
        add_typed(32'd1, 32'd4, 0, 0, 12'd0, 12'd0, SRC_NEW);
        add_cfg(REG_CONFIRM_GAP, 16'd100);
        add_motion(10'd0, 10'd0, -16'sd32768, 16'sd32767);
        add_motion(10'd1023, 10'd1023, 16'sd32767, -16'sd32768);
        add_frame(32'd5, 1'b1, 12'd7, 12'd7, 12'd7, 12'd7);
        add_frame(32'd6, 1'b1, 12'd100, 12'd100, 12'd8, 12'd8);
        add_typed(32'd1, 32'd6, 25600, 25600, 12'd8, 12'd8, SRC_REFRESH);
        // corners on, just inside and just outside the box edges
        add_motion(10'd25, 10'd25, 16'sd1, -16'sd1);
        add_motion(10'd24, 10'd24, 16'sd2, -16'sd2);
        add_motion(10'd27, 10'd27, -16'sd7, 16'sd5);
        add_motion(10'd28, 10'd28, 16'sd1000, 16'sd1000);
        add_motion(10'd23, 10'd23, 16'sd1000, 16'sd1000);
        add_frame(32'd7, 1'b1, 12'd1, 12'd1, 12'd1, 12'd1);
        add_frame(32'd106, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0);
        add_cfg(REG_SEARCH_GAP, 16'hFFFF);
        add_frame(32'd107, 1'b1, 12'd9, 12'd9, 12'd9, 12'd9);
        add_frame(32'd65641, 1'b1, 12'd1, 12'd2, 12'd3, 12'd4);
        add_typed(32'd2, 32'd65641, 256, 512, 12'd3, 12'd4, SRC_NEW);
        // frame numbers that wrap around
        add_frame(32'd65640, 1'b1, 12'd4095, 12'd0, 12'd0, 12'd4095);
        add_typed(32'd2, 32'd65640, 1048320, 0, 12'd0, 12'd4095, SRC_REFRESH);
        add_frame(32'hFFFF_FFFF, 1'b1, 12'd300, 12'd200, 12'd50, 12'd60);
        add_frame(32'd1, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 11;
        recv_idle_pct = 46;
        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                settle();
                write_reg(script[i].reg_idx, script[i].reg_val);
            end
            else
                send_req(script[i].req, script[i].typed, script[i].want);
        end
        frame_cur = 32'd1;

        // random phases across gap settings and idling patterns
        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            write_reg(REG_SEARCH_GAP, s_gap[ph]);
            write_reg(REG_CONFIRM_GAP, c_gap[ph]);
            send_idle_pct = (ph < 2) ? 11 : (ph < 4) ? 46 : 0;
            recv_idle_pct = (ph < 2) ? 46 : (ph < 4) ? 11 : 0;
            if (ph == 4)
                hold_len = HOLD_LEN;
            done = 0;
            while (done < PHASE_LEN)
            begin
                rand_req(r);
                send_req(r, 1'b0, no_box);
                done++;
            end
        end

        settle();
        if (pending_boxes.size() != 0)
            report_mismatch("boxes never delivered", pending_boxes.size(), 0);
        $display("run covered %0d effective input transactions and %0d boxes", n_effective,
                 n_src[0] + n_src[1] + n_src[2] + n_src[3]);
        $display("boxes: %0d new, %0d refreshed, %0d moved; samples past saturation: %0d",
                 n_src[SRC_NEW], n_src[SRC_REFRESH], n_src[SRC_MOTION], n_sat_hits);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### motion_vector_box_tracker_core.f
design/mvbt_pkg.sv
design/mvbt_ctrl.sv
design/mvbt_datapath.sv
design/motion_vector_box_tracker_core.sv
dv/tb_top.sv
